/* rtl/core/bsc_pkg.sv */
package bsc_pkg;

  localparam int DIV_BITS = 32;

  localparam logic [2:0] REG_AC1_AC2  = 3'd0;
  localparam logic [2:0] REG_AC3_AC4  = 3'd1;
  localparam logic [2:0] REG_AC5_AC6  = 3'd2;
  localparam logic [2:0] REG_B1_B2    = 3'd3;
  localparam logic [2:0] REG_MC_MD    = 3'd4;
  localparam logic [2:0] REG_OSS      = 3'd5;

  localparam logic [31:0] B6_OFFSET   = 32'd4000;
  localparam logic [31:0] B4_OFFSET   = 32'd32768;
  localparam logic [31:0] B7_SCALE    = 32'd50000;
  localparam logic [31:0] P_K1        = 32'd3038;
  localparam logic [31:0] P_K2        = 32'hFFFF_E343;  // -7357
  localparam logic [31:0] P_K3        = 32'd3791;

  // sideband across the temperature divider
  typedef struct packed {
    logic [31:0] x1;
    logic [23:0] up;
    logic        neg;
    logic        err;
  } d1_side_t;

  // sideband across the pressure divider
  typedef struct packed {
    logic [15:0] temp;
    logic        hi;
    logic        err;
  } d2_side_t;

endpackage

/* rtl/core/bsc_div.sv */
module bsc_div (
  input  logic        clk,
  input  logic        en,
  input  logic [31:0] num,
  input  logic [31:0] den,
  output logic [31:0] quo
);
  import bsc_pkg::*;

  // one quotient bit per stage, restoring
  logic [31:0] rem_q [0:DIV_BITS-1];
  logic [31:0] nq_q  [0:DIV_BITS-1];
  logic [31:0] dv_q  [0:DIV_BITS-1];

  genvar i;
  generate
    for (i = 0; i < DIV_BITS; i++) begin : g_stage
      logic [31:0] rem_in, nq_in, dv_in;
      logic [32:0] trial, diff;
      logic        take;
      if (i == 0) begin : g_first
        assign rem_in = '0;
        assign nq_in  = num;
        assign dv_in  = den;
      end else begin : g_next
        assign rem_in = rem_q[i-1];
        assign nq_in  = nq_q[i-1];
        assign dv_in  = dv_q[i-1];
      end
      assign trial = {rem_in, nq_in[31]};
      assign diff  = trial - {1'b0, dv_in};
      assign take  = trial >= {1'b0, dv_in};
      always_ff @(posedge clk) begin
        if (en) begin
          rem_q[i] <= take ? diff[31:0] : trial[31:0];
          nq_q[i]  <= {nq_in[30:0], take};
          dv_q[i]  <= dv_in;
        end
      end
    end
  endgenerate

  assign quo = nq_q[DIV_BITS-1];
endmodule

/* rtl/core/barometric_sensor_compensation.sv */
// Structure: two 32-stage restoring dividers plus 13 arithmetic stages
// lie between the input transfer and the result.
// Throughput: one item per cycle; the whole pipeline holds while the
// result waits for m_tready.
// Reset (synchronous, rst high) clears all valid bits and the calibration
// registers; no clearing pass.
module barometric_sensor_compensation (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        s_tvalid,
  output logic        s_tready,
  // raw_temperature[15:0], raw_pressure_high[23:16], raw_pressure_mid[31:24],
  // raw_pressure_low[39:32]
  input  logic [39:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // temperature_tenths[15:0], pressure_pa[47:16]
  output logic [47:0] m_tdata,
  // divide_error[0]
  output logic        m_tuser
);
  import bsc_pkg::*;

  logic [31:0] r_ac1_ac2, r_ac3_ac4, r_ac5_ac6, r_b1_b2, r_mc_md;
  logic [1:0]  r_oss;
  logic [2:0]  reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      r_ac1_ac2 <= '0;
      r_ac3_ac4 <= '0;
      r_ac5_ac6 <= '0;
      r_b1_b2   <= '0;
      r_mc_md   <= '0;
      r_oss     <= '0;
    end else if (psel && penable && pwrite && (paddr[1:0] == 2'b00)) begin
      case (reg_idx)
        REG_AC1_AC2: r_ac1_ac2 <= pwdata;
        REG_AC3_AC4: r_ac3_ac4 <= pwdata;
        REG_AC5_AC6: r_ac5_ac6 <= pwdata;
        REG_B1_B2:   r_b1_b2   <= pwdata;
        REG_MC_MD:   r_mc_md   <= pwdata;
        REG_OSS:     r_oss     <= pwdata[1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[1:0] == 2'b00) begin
      case (reg_idx)
        REG_AC1_AC2: prdata = r_ac1_ac2;
        REG_AC3_AC4: prdata = r_ac3_ac4;
        REG_AC5_AC6: prdata = r_ac5_ac6;
        REG_B1_B2:   prdata = r_b1_b2;
        REG_MC_MD:   prdata = r_mc_md;
        REG_OSS:     prdata = {30'd0, r_oss};
        default:     prdata = '0;
      endcase
    end
  end

  // coefficients, extended to 32 bits
  logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, cb1, cb2, mc, md;
  assign ac1 = {{16{r_ac1_ac2[31]}}, r_ac1_ac2[31:16]};
  assign ac2 = {{16{r_ac1_ac2[15]}}, r_ac1_ac2[15:0]};
  assign ac3 = {{16{r_ac3_ac4[31]}}, r_ac3_ac4[31:16]};
  assign ac4 = {16'd0, r_ac3_ac4[15:0]};
  assign ac5 = {16'd0, r_ac5_ac6[31:16]};
  assign ac6 = {16'd0, r_ac5_ac6[15:0]};
  assign cb1 = {{16{r_b1_b2[31]}}, r_b1_b2[31:16]};
  assign cb2 = {{16{r_b1_b2[15]}}, r_b1_b2[15:0]};
  assign mc  = {{16{r_mc_md[31]}}, r_mc_md[31:16]};
  assign md  = {{16{r_mc_md[15]}}, r_mc_md[15:0]};

  logic en;
  assign en       = !(m_tvalid && !m_tready);
  assign s_tready = en;

  // stage 1
  logic        v1;
  logic [31:0] s1_prod;
  logic [23:0] s1_up;
  logic [23:0] raw_p;
  assign raw_p = {s_tdata[23:16], s_tdata[31:24], s_tdata[39:32]};

  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else if (en) v1 <= s_tvalid;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      s1_prod <= ({16'd0, s_tdata[15:0]} - ac6) * ac5;
      s1_up   <= raw_p >> (4'd8 - {2'd0, r_oss});
    end
  end

  // stage 2: divider operands for mc<<11 / (x1+md)
  logic        v2;
  logic [31:0] s2_x1, s2_num, s2_den;
  logic [23:0] s2_up;
  logic        s2_neg, s2_err;
  logic [31:0] c2_x1, c2_den, c2_num;
  assign c2_x1  = $signed(s1_prod) >>> 15;
  assign c2_den = c2_x1 + md;
  assign c2_num = mc << 11;

  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else if (en) v2 <= v1;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      s2_x1  <= c2_x1;
      s2_up  <= s1_up;
      s2_num <= c2_num[31] ? -c2_num : c2_num;
      s2_den <= c2_den[31] ? -c2_den : c2_den;
      s2_neg <= c2_num[31] ^ c2_den[31];
      s2_err <= (c2_den == 32'd0);
    end
  end

  logic [31:0] q1;
  bsc_div u_div_t (.clk(clk), .en(en), .num(s2_num), .den(s2_den), .quo(q1));

  d1_side_t              side1 [0:DIV_BITS-1];
  logic [DIV_BITS-1:0]   vd1;
  always_ff @(posedge clk) begin
    if (rst) vd1 <= '0;
    else if (en) vd1 <= {vd1[DIV_BITS-2:0], v2};
  end
  always_ff @(posedge clk) begin
    if (en) begin
      side1[0] <= '{x1: s2_x1, up: s2_up, neg: s2_neg, err: s2_err};
      for (int k = 1; k < DIV_BITS; k++) side1[k] <= side1[k-1];
    end
  end

  d1_side_t sd1;
  assign sd1 = side1[DIV_BITS-1];

  // stage 3: b5, temperature, b6
  logic        v3;
  logic [31:0] s3_b6;
  logic [15:0] s3_temp;
  logic [23:0] s3_up;
  logic        s3_err;
  logic [31:0] c3_x2, c3_b5, c3_tw;
  logic [15:0] c3_sat;
  assign c3_x2 = sd1.neg ? -q1 : q1;
  assign c3_b5 = sd1.x1 + c3_x2;
  assign c3_tw = $signed(c3_b5 + 32'd8) >>> 4;
  always_comb begin
    if ($signed(c3_tw) > $signed(32'sd32767)) c3_sat = 16'h7FFF;
    else if ($signed(c3_tw) < $signed(-32'sd32768)) c3_sat = 16'h8000;
    else c3_sat = c3_tw[15:0];
  end

  always_ff @(posedge clk) begin
    if (rst) v3 <= 1'b0;
    else if (en) v3 <= vd1[DIV_BITS-1];
  end
  always_ff @(posedge clk) begin
    if (en) begin
      s3_b6   <= c3_b5 - B6_OFFSET;
      s3_temp <= c3_sat;
      s3_up   <= sd1.up;
      s3_err  <= sd1.err;
    end
  end

  // stage 4: products of b6
  logic        v4;
  logic [31:0] s4_b6sq, s4_a2, s4_a3;
  logic [15:0] s4_temp;
  logic [23:0] s4_up;
  logic        s4_err;
  always_ff @(posedge clk) begin
    if (rst) v4 <= 1'b0;
    else if (en) v4 <= v3;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      s4_b6sq <= s3_b6 * s3_b6;
      s4_a2   <= ac2 * s3_b6;
      s4_a3   <= ac3 * s3_b6;
      s4_temp <= s3_temp;
      s4_up   <= s3_up;
      s4_err  <= s3_err;
    end
  end

  // stage 5: products of sq and scaled b6 products
  logic        v5;
  logic [31:0] s5_pb1, s5_pb2, s5_x2a, s5_x1c;
  logic [15:0] s5_temp;
  logic [23:0] s5_up;
  logic        s5_err;
  logic [31:0] c5_sq;
  assign c5_sq = $signed(s4_b6sq) >>> 12;
  always_ff @(posedge clk) begin
    if (rst) v5 <= 1'b0;
    else if (en) v5 <= v4;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      s5_pb1  <= cb1 * c5_sq;
      s5_pb2  <= cb2 * c5_sq;
      s5_x2a  <= $signed(s4_a2) >>> 11;
      s5_x1c  <= $signed(s4_a3) >>> 13;
      s5_temp <= s4_temp;
      s5_up   <= s4_up;
      s5_err  <= s4_err;
    end
  end

  // stage 6: b3 and x3 of the b4 path
  logic        v6;
  logic [31:0] s6_b3, s6_x3;
  logic [15:0] s6_temp;
  logic [23:0] s6_up;
  logic        s6_err;
  logic [31:0] c6_x3a, c6_b3i;
  assign c6_x3a = $unsigned($signed(s5_pb2) >>> 11) + s5_x2a;
  assign c6_b3i = ((ac1 << 2) + c6_x3a) << r_oss;
  always_ff @(posedge clk) begin
    if (rst) v6 <= 1'b0;
    else if (en) v6 <= v5;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      s6_b3   <= $signed(c6_b3i + 32'd2) >>> 2;
      s6_x3   <= $signed(s5_x1c + $unsigned($signed(s5_pb1) >>> 16) + 32'd2) >>> 2;
      s6_temp <= s5_temp;
      s6_up   <= s5_up;
      s6_err  <= s5_err;
    end
  end

  // stage 7
  logic        v7;
  logic [31:0] s7_p4, s7_upb;
  logic [15:0] s7_temp;
  logic        s7_err;
  always_ff @(posedge clk) begin
    if (rst) v7 <= 1'b0;
    else if (en) v7 <= v6;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      s7_p4   <= ac4 * (s6_x3 + B4_OFFSET);
      s7_upb  <= {8'd0, s6_up} - s6_b3;
      s7_temp <= s6_temp;
      s7_err  <= s6_err;
    end
  end

  // stage 8: b4, b7
  logic        v8;
  logic [31:0] s8_b4, s8_b7;
  logic [15:0] s8_temp;
  logic        s8_err;
  always_ff @(posedge clk) begin
    if (rst) v8 <= 1'b0;
    else if (en) v8 <= v7;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      s8_b4   <= s7_p4 >> 15;
      s8_b7   <= s7_upb * (B7_SCALE >> r_oss);
      s8_temp <= s7_temp;
      s8_err  <= s7_err;
    end
  end

  // stage 9: operands of the pressure divide
  logic        v9;
  logic [31:0] s9_num, s9_den;
  d2_side_t    s9_side;
  always_ff @(posedge clk) begin
    if (rst) v9 <= 1'b0;
    else if (en) v9 <= v8;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      s9_num  <= s8_b7[31] ? s8_b7 : (s8_b7 << 1);
      s9_den  <= s8_b4;
      s9_side <= '{temp: s8_temp, hi: s8_b7[31], err: s8_err || (s8_b4 == 32'd0)};
    end
  end

  logic [31:0] q2;
  bsc_div u_div_p (.clk(clk), .en(en), .num(s9_num), .den(s9_den), .quo(q2));

  d2_side_t              side2 [0:DIV_BITS-1];
  logic [DIV_BITS-1:0]   vd2;
  always_ff @(posedge clk) begin
    if (rst) vd2 <= '0;
    else if (en) vd2 <= {vd2[DIV_BITS-2:0], v9};
  end
  always_ff @(posedge clk) begin
    if (en) begin
      side2[0] <= s9_side;
      for (int k = 1; k < DIV_BITS; k++) side2[k] <= side2[k-1];
    end
  end

  d2_side_t sd2;
  assign sd2 = side2[DIV_BITS-1];

  // stage 10: p
  logic        v10;
  logic [31:0] s10_p;
  logic [15:0] s10_temp;
  logic        s10_err;
  always_ff @(posedge clk) begin
    if (rst) v10 <= 1'b0;
    else if (en) v10 <= vd2[DIV_BITS-1];
  end
  always_ff @(posedge clk) begin
    if (en) begin
      s10_p    <= sd2.hi ? (q2 << 1) : q2;
      s10_temp <= sd2.temp;
      s10_err  <= sd2.err;
    end
  end

  // stage 11
  logic        v11;
  logic [31:0] s11_p, s11_sq, s11_m7;
  logic [15:0] s11_temp;
  logic        s11_err;
  logic [31:0] c11_p8;
  assign c11_p8 = $signed(s10_p) >>> 8;
  always_ff @(posedge clk) begin
    if (rst) v11 <= 1'b0;
    else if (en) v11 <= v10;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      s11_p    <= s10_p;
      s11_sq   <= c11_p8 * c11_p8;
      s11_m7   <= P_K2 * s10_p;
      s11_temp <= s10_temp;
      s11_err  <= s10_err;
    end
  end

  // stage 12
  logic        v12;
  logic [31:0] s12_p, s12_m3, s12_x2;
  logic [15:0] s12_temp;
  logic        s12_err;
  always_ff @(posedge clk) begin
    if (rst) v12 <= 1'b0;
    else if (en) v12 <= v11;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      s12_p    <= s11_p;
      s12_m3   <= s11_sq * P_K1;
      s12_x2   <= $signed(s11_m7) >>> 16;
      s12_temp <= s11_temp;
      s12_err  <= s11_err;
    end
  end

  // stage 13: output register
  logic [31:0] c13_sum, c13_p;
  assign c13_sum = $unsigned($signed(s12_m3) >>> 16) + s12_x2 + P_K3;
  assign c13_p   = s12_p + $unsigned($signed(c13_sum) >>> 4);

  always_ff @(posedge clk) begin
    if (rst) m_tvalid <= 1'b0;
    else if (en) m_tvalid <= v12;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      m_tdata <= s12_err ? 48'd0 : {c13_p, s12_temp};
      m_tuser <= s12_err;
    end
  end
endmodule

/* rtl/core/bsc_checker.sv */
module bsc_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [47:0] m_tdata,
  input logic        m_tuser
);
  import bsc_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed while stalled");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata == 48'd0)
    else $error("divide error with nonzero results");

  a_reset: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid after reset");

  a_ready: assert property (@(posedge clk) disable iff (rst)
    s_tready == !(m_tvalid && !m_tready))
    else $error("input ready does not follow output stall");
endmodule

bind barometric_sensor_compensation bsc_checker u_bsc_checker (
  .clk(clk), .rst(rst), .s_tready(s_tready), .m_tvalid(m_tvalid),
  .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
);
